// ===== src/mpc_pkg.sv =====
// ----------------------------------------------------------------------------
// mpc_pkg: shared types and constants of the PWM capture block
// Request and result records that run along the channel chain, register
// indexes, command codes and the servo angle conversion.
// ----------------------------------------------------------------------------
package mpc_pkg;

  localparam int CHANNELS_DEF  = 8;
  localparam int TIME_BITS_DEF = 32;
  localparam int HISTORY_DEF   = 3;

  localparam int LEVEL_BITS    = 8;
  localparam int CHAN_BITS     = 3;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;
  localparam int ANGLE_BITS    = 9;
  localparam int DIST_BITS     = 11;
  localparam int OUT_BITS      = 32;

  localparam logic [15:0] MAX_WIDTH_RST = 16'd1100;
  localparam logic [8:0]  TOL_RST       = 9'd10;

  // angle = floor((w - 30) * 360 / 1036); saturates once w - 30 reaches 1474
  localparam logic [15:0] ANGLE_OFFSET = 16'd30;
  localparam logic [15:0] ANGLE_SAT_D  = 16'd1474;
  // 90 * ceil(2^26 / 259), exact for every distance below the saturation point
  localparam logic [24:0] ANGLE_RECIP  = 25'd23319720;
  localparam int          ANGLE_SHIFT  = 26;
  localparam logic [8:0]  ANGLE_MAX    = 9'd511;

  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ENABLE    = 2'd0,
    REG_MAX_WIDTH = 2'd1,
    REG_TOLERANCE = 2'd2
  } reg_e;

  typedef struct packed {
    logic                 valid;
    cmd_e                 cmd;
    logic [CHAN_BITS-1:0] channel;
  } item_t;

  typedef struct packed {
    logic                                 hit;
    logic [OUT_BITS-1:0]                  pulse_width;
    logic                                 width_valid;
    logic [OUT_BITS-1:0]                  period;
    logic                                 period_valid;
    logic [HISTORY_DEF-1:0][ANGLE_BITS-1:0] hist;
    logic                                 pend;
    logic [DIST_BITS-1:0]                 pend_dist;
    logic                                 pend_sat;
  } res_t;

  function automatic logic [ANGLE_BITS-1:0] angle_of(input logic [DIST_BITS-1:0] span,
                                                     input logic sat);
    logic [DIST_BITS+24:0] prod;
    prod = (DIST_BITS + 25)'(span) * (DIST_BITS + 25)'(ANGLE_RECIP);
    return sat ? ANGLE_MAX : prod[ANGLE_SHIFT +: ANGLE_BITS];
  endfunction

endpackage

// ===== src/mpc_cell.sv =====
// ----------------------------------------------------------------------------
// mpc_cell: capture cell of one channel
// Holds the edge times, level and angle history of its channel, applies each
// passing request to them and hands the request on to the next cell.
// ----------------------------------------------------------------------------
module mpc_cell #(
  parameter int IDX       = 0,
  parameter int TIME_BITS = mpc_pkg::TIME_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           adv_i,
  input  logic                           en_i,
  input  logic                           load_i,
  input  logic [TIME_BITS-1:0]           time_i,
  input  logic [15:0]                    max_width_i,
  input  mpc_pkg::item_t                 item_i,
  input  logic [TIME_BITS-1:0]           stamp_i,
  input  logic [mpc_pkg::LEVEL_BITS-1:0] levels_i,
  input  mpc_pkg::res_t                  res_i,
  output mpc_pkg::item_t                 item_o,
  output logic [TIME_BITS-1:0]           stamp_o,
  output logic [mpc_pkg::LEVEL_BITS-1:0] levels_o,
  output mpc_pkg::res_t                  res_o
);

  localparam int DB = (TIME_BITS < 32) ? TIME_BITS : 32;

  logic [TIME_BITS-1:0] rise_q, earl_q, fall_q;
  logic [mpc_pkg::HISTORY_DEF-1:0][mpc_pkg::ANGLE_BITS-1:0] hist_q;
  logic                            pend_q, pend_d;
  logic [mpc_pkg::DIST_BITS-1:0]   pdist_q, pdist_d;
  logic                            psat_q, psat_d;
  logic                            prev_q;
  mpc_pkg::item_t                  item_q;
  logic [TIME_BITS-1:0]            stamp_q;
  logic [mpc_pkg::LEVEL_BITS-1:0]  levels_q;
  mpc_pkg::res_t                   res_q, res_d;

  logic [31:0]          lv_ext;
  logic                 lvl, tick, chg, rise_ev, fall_ev, hit;
  logic [TIME_BITS-1:0] wf, wq, pq;
  logic [DB-1:0]        wf_t, wq_t, pq_t;
  logic                 wf_ok;
  logic [15:0]          dd;

  assign lv_ext = 32'(levels_i);

  always_comb begin
    lvl     = lv_ext[IDX];
    tick    = item_i.valid && (item_i.cmd == mpc_pkg::CMD_TICK);
    chg     = en_i && (lvl != prev_q);
    rise_ev = tick && chg && lvl;
    fall_ev = tick && chg && !lvl;
    hit     = item_i.valid && (item_i.cmd == mpc_pkg::CMD_QUERY) && en_i &&
              ({2'b00, item_i.channel} == 5'(IDX));

    wf    = stamp_i - rise_q;
    wf_t  = wf[DB-1:0];
    wf_ok = !wf_t[DB-1] && (wf_t <= DB'(max_width_i));
    dd    = wf_t[15:0] - mpc_pkg::ANGLE_OFFSET;
    if (wf_t[15:0] < mpc_pkg::ANGLE_OFFSET) begin
      pdist_d = '0;
      psat_d  = 1'b0;
    end else begin
      pdist_d = dd[mpc_pkg::DIST_BITS-1:0];
      psat_d  = dd >= mpc_pkg::ANGLE_SAT_D;
    end
    pend_d = fall_ev && wf_ok;

    wq   = fall_q - rise_q;
    pq   = rise_q - earl_q;
    wq_t = wq[DB-1:0];
    pq_t = pq[DB-1:0];

    res_d = res_i;
    if (hit) begin
      res_d.hit          = 1'b1;
      res_d.pulse_width  = 32'(wq_t);
      res_d.width_valid  = !wq_t[DB-1] && (wq_t <= DB'(max_width_i));
      res_d.period       = 32'(pq_t);
      res_d.period_valid = !pq_t[DB-1];
      res_d.hist         = hist_q;
      res_d.pend         = pend_q;
      res_d.pend_dist    = pdist_q;
      res_d.pend_sat     = psat_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rise_q <= '0;
      earl_q <= '0;
      fall_q <= '0;
      hist_q <= '0;
      pend_q <= 1'b0;
      prev_q <= 1'b1;
      item_q <= '0;
    end else begin
      if (load_i) begin
        earl_q <= time_i;
      end
      if (adv_i) begin
        item_q <= item_i;
        if (pend_q) begin
          hist_q <= {mpc_pkg::angle_of(pdist_q, psat_q), hist_q[2], hist_q[1]};
        end
        pend_q <= pend_d;
        if (tick) begin
          prev_q <= lvl;
        end
        if (rise_ev) begin
          earl_q <= rise_q;
          rise_q <= stamp_i;
        end
        if (fall_ev) begin
          fall_q <= stamp_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      stamp_q  <= stamp_i;
      levels_q <= levels_i;
      res_q    <= res_d;
      if (pend_d) begin
        pdist_q <= pdist_d;
        psat_q  <= psat_d;
      end
    end
  end

  assign item_o   = item_q;
  assign stamp_o  = stamp_q;
  assign levels_o = levels_q;
  assign res_o    = res_q;

endmodule

// ===== src/mpc_vote.sv =====
// ----------------------------------------------------------------------------
// mpc_vote: angle voter and result register
// Completes a pending angle push for the queried channel, votes over the
// three latest angles and holds the result until the sink takes it.
// ----------------------------------------------------------------------------
module mpc_vote (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [8:0]                     tol_i,
  input  mpc_pkg::item_t                 item_i,
  input  mpc_pkg::res_t                  res_i,
  output logic                           adv_o,
  output logic                           valid_o,
  input  logic                           ready_i,
  output logic [mpc_pkg::OUT_BITS-1:0]   pulse_width_o,
  output logic                           width_valid_o,
  output logic [mpc_pkg::OUT_BITS-1:0]   period_o,
  output logic                           period_valid_o,
  output logic [mpc_pkg::ANGLE_BITS-1:0] angle_o,
  output logic                           angle_valid_o
);

  logic          aq_q;
  mpc_pkg::res_t ares_q;
  mpc_pkg::res_t ares_d;
  logic          out_valid_q;

  logic [mpc_pkg::OUT_BITS-1:0]   pw_q, per_q;
  logic                           wv_q, pv_q, av_q;
  logic [mpc_pkg::ANGLE_BITS-1:0] ang_q;

  logic [8:0] a1, a2, a3, d12, d23, d13, ang_d;
  logic [9:0] s12, s23, s13;
  logic       av_d;

  assign adv_o = !(aq_q && out_valid_q && !ready_i);

  always_comb begin
    ares_d = res_i;
    if (res_i.pend) begin
      ares_d.hist = {mpc_pkg::angle_of(res_i.pend_dist, res_i.pend_sat),
                     res_i.hist[2], res_i.hist[1]};
    end
  end

  always_comb begin
    a1  = ares_q.hist[0];
    a2  = ares_q.hist[1];
    a3  = ares_q.hist[2];
    d12 = (a1 > a2) ? a1 - a2 : a2 - a1;
    d23 = (a2 > a3) ? a2 - a3 : a3 - a2;
    d13 = (a1 > a3) ? a1 - a3 : a3 - a1;
    s12 = {1'b0, a1} + {1'b0, a2};
    s23 = {1'b0, a2} + {1'b0, a3};
    s13 = {1'b0, a1} + {1'b0, a3};
    ang_d = '0;
    av_d  = 1'b0;
    if (d12 < tol_i) begin
      ang_d = s12[9:1];
      av_d  = 1'b1;
    end else if (d23 < tol_i) begin
      ang_d = s23[9:1];
      av_d  = 1'b1;
    end else if (d13 < tol_i) begin
      ang_d = s13[9:1];
      av_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aq_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv_o) begin
        aq_q <= item_i.valid && (item_i.cmd == mpc_pkg::CMD_QUERY);
      end
      if (aq_q && adv_o) begin
        out_valid_q <= 1'b1;
      end else if (ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      ares_q <= ares_d;
    end
    if (aq_q && adv_o) begin
      // a query that found no enabled channel reports all zeros
      pw_q  <= ares_q.hit ? ares_q.pulse_width : '0;
      wv_q  <= ares_q.hit && ares_q.width_valid;
      per_q <= ares_q.hit ? ares_q.period : '0;
      pv_q  <= ares_q.hit && ares_q.period_valid;
      ang_q <= ares_q.hit ? ang_d : '0;
      av_q  <= ares_q.hit && av_d;
    end
  end

  assign valid_o        = out_valid_q;
  assign pulse_width_o  = pw_q;
  assign width_valid_o  = wv_q;
  assign period_o       = per_q;
  assign period_valid_o = pv_q;
  assign angle_o        = ang_q;
  assign angle_valid_o  = av_q;

endmodule

// ===== src/multi_channel_pwm_capture.sv =====
// ----------------------------------------------------------------------------
// multi_channel_pwm_capture: eight-channel PWM capture with servo angle vote
// Ticks stamp edges per channel; queries return width, period and voted
// angle of one channel.
// ----------------------------------------------------------------------------
// One request is taken every cycle, ticks and queries alike. Each request
// walks a chain of one capture cell per channel, then an angle stage and a
// vote stage, where a query's result is registered. The input stalls only
// while a query sits in the angle stage and the previous result has not yet
// been taken. There is no clearing pass after reset. Configuration writes
// are taken in any cycle but must be issued only with no request in flight.
module multi_channel_pwm_capture #(
  parameter int CHANNELS  = mpc_pkg::CHANNELS_DEF,
  parameter int TIME_BITS = mpc_pkg::TIME_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [15:0]                       s_axis_tdata_i,  // levels[7:0], channel[10:8]
  input  logic                              s_axis_tuser_i,  // command[0]
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // pulse_width[31:0], width_valid[32], period[64:33], period_valid[65],
  // angle[74:66], angle_valid[75]
  output logic [79:0]                       m_axis_tdata_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [mpc_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [mpc_pkg::CFG_DATA_BITS-1:0] cfg_data_i
);

  logic [7:0]           enable_q, enable_d;
  logic [15:0]          maxw_q, maxw_d;
  logic [8:0]           tol_q, tol_d;
  logic [TIME_BITS-1:0] time_q;
  logic [7:0]           added;
  logic [CHANNELS-1:0]  en_ext, load_ext;
  logic                 adv, cfg_wr, tick_acc;

  mpc_pkg::item_t                 chain_item   [CHANNELS+1];
  logic [TIME_BITS-1:0]           chain_stamp  [CHANNELS+1];
  logic [mpc_pkg::LEVEL_BITS-1:0] chain_levels [CHANNELS+1];
  mpc_pkg::res_t                  chain_res    [CHANNELS+1];

  logic [mpc_pkg::OUT_BITS-1:0]   pulse_width, period;
  logic                           width_valid, period_valid, angle_valid;
  logic [mpc_pkg::ANGLE_BITS-1:0] angle;

  assign cfg_ready_o     = 1'b1;
  assign cfg_wr          = cfg_valid_i && cfg_ready_o;
  assign s_axis_tready_o = adv;
  assign tick_acc        = s_axis_tvalid_i && adv && (s_axis_tuser_i == mpc_pkg::CMD_TICK);

  always_comb begin
    enable_d = enable_q;
    maxw_d   = maxw_q;
    tol_d    = tol_q;
    added    = '0;
    if (cfg_wr) begin
      unique case (mpc_pkg::reg_e'(cfg_index_i))
        mpc_pkg::REG_ENABLE: begin
          enable_d = cfg_data_i[7:0];
          added    = cfg_data_i[7:0] & ~enable_q;
        end
        mpc_pkg::REG_MAX_WIDTH: maxw_d = cfg_data_i;
        mpc_pkg::REG_TOLERANCE: tol_d  = cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= '0;
      maxw_q   <= mpc_pkg::MAX_WIDTH_RST;
      tol_q    <= mpc_pkg::TOL_RST;
      time_q   <= '0;
    end else begin
      enable_q <= enable_d;
      maxw_q   <= maxw_d;
      tol_q    <= tol_d;
      if (tick_acc) begin
        time_q <= time_q + TIME_BITS'(1);
      end
    end
  end

  assign en_ext   = CHANNELS'(enable_q);
  assign load_ext = CHANNELS'(added);

  always_comb begin
    chain_item[0].valid   = s_axis_tvalid_i;
    chain_item[0].cmd     = mpc_pkg::cmd_e'(s_axis_tuser_i);
    chain_item[0].channel = s_axis_tdata_i[10:8];
    chain_stamp[0]        = time_q;
    chain_levels[0]       = s_axis_tdata_i[7:0];
    chain_res[0]          = '0;
  end

  for (genvar i = 0; i < CHANNELS; i++) begin : g_cell
    mpc_cell #(
      .IDX       (i),
      .TIME_BITS (TIME_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .adv_i       (adv),
      .en_i        (en_ext[i]),
      .load_i      (load_ext[i]),
      .time_i      (time_q),
      .max_width_i (maxw_q),
      .item_i      (chain_item[i]),
      .stamp_i     (chain_stamp[i]),
      .levels_i    (chain_levels[i]),
      .res_i       (chain_res[i]),
      .item_o      (chain_item[i+1]),
      .stamp_o     (chain_stamp[i+1]),
      .levels_o    (chain_levels[i+1]),
      .res_o       (chain_res[i+1])
    );
  end

  mpc_vote u_vote (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .tol_i          (tol_q),
    .item_i         (chain_item[CHANNELS]),
    .res_i          (chain_res[CHANNELS]),
    .adv_o          (adv),
    .valid_o        (m_axis_tvalid_o),
    .ready_i        (m_axis_tready_i),
    .pulse_width_o  (pulse_width),
    .width_valid_o  (width_valid),
    .period_o       (period),
    .period_valid_o (period_valid),
    .angle_o        (angle),
    .angle_valid_o  (angle_valid)
  );

  assign m_axis_tdata_o = {4'b0000, angle_valid, angle, period_valid, period,
                           width_valid, pulse_width};

`ifndef ASSERT_OFF
  a_time_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_acc |=> time_q == $past(time_q) + TIME_BITS'(1))
    else $error("time counter did not advance on a tick");

  a_time_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !tick_acc |=> $stable(time_q))
    else $error("time counter moved without a tick");

  a_take_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i) |-> s_axis_tready_o)
    else $error("input stalled while the result was taken");

  a_empty_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with an empty result register");
`endif

endmodule
